@@ rtl/core/pps_pkg.sv @@
// Shared types and constants for the PIR partition sum and share block.
// Used by pps_divmod and pir_partition_sum_and_share; no dependencies.
package pps_pkg;

	// Command codes carried in s_tuser
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_SELECT = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// Configuration register indexes
	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_PLAIN_MOD  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_CIPHER_MOD = 2'd1;
	localparam logic [CFG_AW-1:0] REG_EMB_DIM    = 2'd2;
	localparam int CFG_DW = 62;

	// Remainder engine widths: dividend c*p + q/2 stays below 2^95
	localparam int DVD_W = 95;
	localparam int MOD_W = 62;
	localparam int CNT_W = 7;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [DVD_W-1:0] dividend;
		logic [MOD_W-1:0] modulus;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/core/pps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/pps_divmod.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Also tracks the quotient reduced mod the plain modulus. Uses pps_pkg.
module pps_divmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pps_pkg::div_req_t          req,
	input  logic [31:0]                plain,
	output pps_pkg::div_stat_t         stat,
	output logic [pps_pkg::MOD_W-1:0]  rem,
	output logic [31:0]                quo_mod
);
	import pps_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] x_q;
	logic [MOD_W-1:0] r_q;
	logic [MOD_W-1:0] mod_q;
	logic [31:0]      qm_q;

	logic [MOD_W:0]   r_sh;
	logic             ge;
	logic [MOD_W:0]   r_sub;
	logic [32:0]      t;
	logic [32:0]      t_red;

	always_comb begin
		r_sh  = {r_q, x_q[DVD_W-1]};
		ge    = r_sh >= {1'b0, mod_q};
		r_sub = ge ? (r_sh - {1'b0, mod_q}) : r_sh;
		t     = {qm_q, ge};
		t_red = (t >= {1'b0, plain}) ? (t - {1'b0, plain}) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// align the top dividend bit with the msb of the shifter
			x_q   <= req.dividend << (CNT_W'(DVD_W) - req.nbits);
			r_q   <= '0;
			qm_q  <= '0;
			mod_q <= req.modulus;
		end else if (busy_q) begin
			x_q  <= x_q << 1;
			r_q  <= r_sub[MOD_W-1:0];
			qm_q <= t_red[31:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = r_q;
	assign quo_mod   = qm_q;

endmodule

@@ rtl/core/pir_partition_sum_and_share.sv @@
// PIR server partition row sum with additive shares mod the plain modulus p.
// Top level; uses pps_pkg, pps_ram (database and two accumulators) and pps_divmod.
//
// Input stream s_*: s_tuser carries the command (load, select, finish), s_tdata
// the operand fields. Output stream m_*: one word per finish item, m_tlast set
// on the last embedding dimension. Registers are written through cfg_we /
// cfg_addr / cfg_data; the user must write them only while the block is idle;
// the block leaves this to the user. Load: one write into the database memory.
// Select: one database word and one accumulator word are read per cycle while
//   the remainder unit is idle, and a sum below 2p is written back in the next
//   cycle; each sum that needs more than one subtract of p is reduced in the
//   remainder unit instead, which holds the reads. With query_start the remaining
//   accumulator words are zeroed, one per cycle, up to MAX_DIM.
// Finish: the bit-serial remainder unit reduces the 64-bit random word, runs
//   the 95-bit scale-round division and reduces each 32-bit accumulator word.
// The block works on one item at a time; s_tready is high only when idle.
// A result waits in the output register while the receiver stalls, and the
// next item is taken meanwhile; a later finish holds until that register frees.
// After reset both accumulators are cleared, one entry per cycle, before the
// first item is taken; the database is undefined until written.
module pir_partition_sum_and_share #(
	parameter int LOG_ENTRIES = 10,
	parameter int MAX_DIM     = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_index, dim_index, db_value, partition_index, row_offset, choice,
	// query_start, coefficient, random_word (from bit 0 up), zero padded
	input  logic [191:0]                  s_tdata,
	// command
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// share_zero, share_one, srv_share, out_dim (from bit 0 up), zero padded
	output logic [103:0]                  m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [pps_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [pps_pkg::CFG_DW-1:0]    cfg_data
);
	import pps_pkg::*;

	localparam int DW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW      = $clog2(MAX_DIM + 1);
	localparam int EW      = LOG_ENTRIES;
	localparam int PB      = LOG_ENTRIES / 2;
	localparam int RB      = LOG_ENTRIES - PB;
	localparam int DB_AW   = EW + DW;
	localparam int DB_DEPTH = 1 << DB_AW;

	typedef enum logic [16:0] {
		ST_CLR    = 17'h00001,
		ST_IDLE   = 17'h00002,
		ST_SEL    = 17'h00004,
		ST_SELCLR = 17'h00008,
		ST_RND_GO = 17'h00010,
		ST_RND_W  = 17'h00020,
		ST_MUL0   = 17'h00040,
		ST_MUL1   = 17'h00080,
		ST_MUL2   = 17'h00100,
		ST_DIV_GO = 17'h00200,
		ST_DIV_W  = 17'h00400,
		ST_ACC_RD = 17'h00800,
		ST_A0_GO  = 17'h01000,
		ST_A0_W   = 17'h02000,
		ST_A1_GO  = 17'h04000,
		ST_A1_W   = 17'h08000,
		ST_OUT    = 17'h10000
	} state_t;

	function automatic logic [31:0] mod_sub(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] p);
		logic [32:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (a < b) begin
			d = d + {1'b0, p};
		end
		return d[31:0];
	endfunction

	// Input fields
	logic [1:0]  in_cmd;
	logic [9:0]  in_entry;
	logic [6:0]  in_dim;
	logic [31:0] in_db;
	logic [4:0]  in_part;
	logic [4:0]  in_row;
	logic        in_choice;
	logic        in_qs;
	logic [61:0] in_coeff;
	logic [63:0] in_rw;

	assign in_cmd    = s_tuser;
	assign in_entry  = s_tdata[9:0];
	assign in_dim    = s_tdata[16:10];
	assign in_db     = s_tdata[48:17];
	assign in_part   = s_tdata[53:49];
	assign in_row    = s_tdata[58:54];
	assign in_choice = s_tdata[59];
	assign in_qs     = s_tdata[60];
	assign in_coeff  = s_tdata[122:61];
	assign in_rw     = s_tdata[186:123];

	state_t       st_q;
	logic [31:0]  p_q;
	logic [61:0]  q_q;
	logic [7:0]   emb_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] words_q;
	logic          v_s1_q;
	logic [DW-1:0] i_s1_q;
	logic [DW-1:0] wi_q;
	logic          out_v_q;

	logic [EW-1:0] entry_q;
	logic          choice_q;
	logic          qs_q;
	logic [6:0]    dim_q;
	logic          dim_ok_q;
	logic          last_q;
	logic [61:0]   c_q;
	logic [63:0]   rw_q;
	logic [62:0]   lo_q;
	logic [62:0]   hi_q;
	logic [DVD_W-1:0] dvd_q;
	logic [31:0]   share_q;
	logic [31:0]   round_q;
	logic [31:0]   a0_q;
	logic [31:0]   a1_q;
	logic [31:0]   o0_q;
	logic [31:0]   o1_q;
	logic [31:0]   os_q;
	logic [6:0]    od_q;
	logic          ol_q;

	logic [31:0] p_eff;
	logic [61:0] q_eff;
	logic        accept;
	logic        load_ok;
	logic        part_ok;
	logic [CW-1:0] words_now;
	logic [EW-1:0] sel_entry;

	logic [31:0] db_rd;
	logic [31:0] a0_rd;
	logic [31:0] a1_rd;
	logic        db_we;
	logic [DB_AW-1:0] db_waddr;
	logic        rd_issue;
	logic        acc_re;
	logic [DW-1:0] acc_raddr;
	logic        acc_we0;
	logic        acc_we1;
	logic [DW-1:0] acc_waddr;
	logic [31:0] acc_wd0;
	logic [31:0] acc_wd1;

	logic [31:0] acc_old;
	logic [32:0] sum;
	logic        fast;
	logic [32:0] sum_red;
	logic        slow;
	logic        sel_end;
	logic        out_free;
	logic [31:0] d0;
	logic [31:0] d1;

	div_req_t    div_req;
	div_stat_t   div_stat;
	logic [MOD_W-1:0] div_rem;
	logic [31:0] div_qm;

	assign p_eff    = (p_q == '0) ? 32'd1 : p_q;
	assign q_eff    = (q_q == '0) ? 62'd1 : q_q;
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;

	assign load_ok   = (32'(in_entry) < (32'd1 << EW)) && (32'(in_dim) < MAX_DIM);
	assign part_ok   = (32'(in_part) < (32'd1 << PB)) && (32'(in_row) < (32'd1 << RB));
	assign sel_entry = EW'((32'(in_part) << RB) | 32'(in_row));
	assign words_now = (32'(emb_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(emb_q);

	assign db_we    = accept && (in_cmd == CMD_LOAD) && load_ok;
	assign db_waddr = {EW'(in_entry), DW'(in_dim)};

	// Select datapath: accumulate the word that was read last cycle
	always_comb begin
		acc_old = qs_q ? 32'd0 : (choice_q ? a1_rd : a0_rd);
		sum     = {1'b0, acc_old} + {1'b0, db_rd};
		fast    = {1'b0, sum} < {p_eff, 1'b0};
		sum_red = (sum >= {1'b0, p_eff}) ? (sum - {1'b0, p_eff}) : sum;
		slow    = (st_q == ST_SEL) && v_s1_q && !fast;
	end

	assign rd_issue = (st_q == ST_SEL) && (idx_q != words_q) && !div_stat.busy && !slow;
	assign sel_end  = (idx_q == words_q) && !v_s1_q && !div_stat.busy;
	assign acc_re    = rd_issue || (st_q == ST_ACC_RD);
	assign acc_raddr = (st_q == ST_ACC_RD) ? DW'(dim_q) : idx_q[DW-1:0];

	always_comb begin
		logic        w;
		logic [31:0] val;
		w         = 1'b0;
		val       = '0;
		acc_we0   = 1'b0;
		acc_we1   = 1'b0;
		acc_waddr = idx_q[DW-1:0];
		acc_wd0   = '0;
		acc_wd1   = '0;
		case (st_q)
			ST_CLR, ST_SELCLR: begin
				acc_we0 = 1'b1;
				acc_we1 = 1'b1;
			end
			ST_SEL: begin
				if (v_s1_q && fast) begin
					w         = 1'b1;
					val       = sum_red[31:0];
					acc_waddr = i_s1_q;
				end else if (div_stat.done) begin
					w         = 1'b1;
					val       = div_rem[31:0];
					acc_waddr = wi_q;
				end
				// the other accumulator is zeroed alongside on a query start
				acc_we0 = w && (!choice_q || qs_q);
				acc_we1 = w && (choice_q || qs_q);
				acc_wd0 = choice_q ? 32'd0 : val;
				acc_wd1 = choice_q ? val : 32'd0;
			end
			default: begin
			end
		endcase
	end

	// Remainder unit requests
	always_comb begin
		div_req.start    = 1'b0;
		div_req.nbits    = CNT_W'(32);
		div_req.dividend = '0;
		div_req.modulus  = MOD_W'(p_eff);
		case (st_q)
			ST_SEL: begin
				div_req.start    = slow;
				div_req.nbits    = CNT_W'(33);
				div_req.dividend = DVD_W'(sum);
			end
			ST_RND_GO: begin
				div_req.start    = 1'b1;
				div_req.nbits    = CNT_W'(64);
				div_req.dividend = DVD_W'(rw_q);
			end
			ST_DIV_GO: begin
				div_req.start    = 1'b1;
				div_req.nbits    = CNT_W'(DVD_W);
				div_req.dividend = dvd_q;
				div_req.modulus  = q_eff;
			end
			ST_A0_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(dim_ok_q ? a0_rd : 32'd0);
			end
			ST_A1_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(dim_ok_q ? a1_rd : 32'd0);
			end
			default: begin
			end
		endcase
	end

	assign d0 = mod_sub(round_q, a0_q, p_eff);
	assign d1 = mod_sub(round_q, a1_q, p_eff);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			p_q     <= 32'd65537;
			q_q     <= 62'h1000000000000000;
			emb_q   <= 8'd128;
			idx_q   <= '0;
			words_q <= '0;
			v_s1_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_PLAIN_MOD:  p_q   <= cfg_data[31:0];
					REG_CIPHER_MOD: q_q   <= cfg_data[61:0];
					REG_EMB_DIM:    emb_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			v_s1_q <= rd_issue;
			if (rd_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (st_q == ST_OUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_CLR, ST_SELCLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(MAX_DIM - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_SELECT: begin
								idx_q   <= '0;
								words_q <= part_ok ? words_now : '0;
								st_q    <= ST_SEL;
							end
							CMD_FINISH: st_q <= ST_RND_GO;
							default: begin
							end
						endcase
					end
				end
				ST_SEL: begin
					if (sel_end) begin
						st_q <= (qs_q && (words_q != CW'(MAX_DIM))) ? ST_SELCLR : ST_IDLE;
					end
				end
				ST_RND_GO: st_q <= ST_RND_W;
				ST_RND_W:  if (div_stat.done) st_q <= ST_MUL0;
				ST_MUL0:   st_q <= ST_MUL1;
				ST_MUL1:   st_q <= ST_MUL2;
				ST_MUL2:   st_q <= ST_DIV_GO;
				ST_DIV_GO: st_q <= ST_DIV_W;
				ST_DIV_W:  if (div_stat.done) st_q <= ST_ACC_RD;
				ST_ACC_RD: st_q <= ST_A0_GO;
				ST_A0_GO:  st_q <= ST_A0_W;
				ST_A0_W:   if (div_stat.done) st_q <= ST_A1_GO;
				ST_A1_GO:  st_q <= ST_A1_W;
				ST_A1_W:   if (div_stat.done) st_q <= ST_OUT;
				ST_OUT:    if (out_free) st_q <= ST_IDLE;
				default:   st_q <= ST_IDLE;
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q  <= sel_entry;
			choice_q <= in_choice;
			qs_q     <= in_qs;
			dim_q    <= in_dim;
			dim_ok_q <= 32'(in_dim) < MAX_DIM;
			last_q   <= ({1'b0, in_dim} + 8'd1) == emb_q;
			c_q      <= in_coeff;
			rw_q     <= in_rw;
		end
		if (rd_issue) begin
			i_s1_q <= idx_q[DW-1:0];
		end
		if (slow) begin
			wi_q <= i_s1_q;
		end
		if (st_q == ST_RND_W && div_stat.done) begin
			share_q <= div_rem[31:0];
		end
		if (st_q == ST_MUL0) begin
			lo_q <= 63'(c_q[30:0]) * 63'(p_eff);
		end
		if (st_q == ST_MUL1) begin
			hi_q <= 63'(c_q[61:31]) * 63'(p_eff);
		end
		if (st_q == ST_MUL2) begin
			dvd_q <= (DVD_W'(hi_q) << 31) + DVD_W'(lo_q) + DVD_W'(q_eff >> 1);
		end
		if (st_q == ST_DIV_W && div_stat.done) begin
			round_q <= div_qm;
		end
		if (st_q == ST_A0_W && div_stat.done) begin
			a0_q <= div_rem[31:0];
		end
		if (st_q == ST_A1_W && div_stat.done) begin
			a1_q <= div_rem[31:0];
		end
		if (st_q == ST_OUT && out_free) begin
			o0_q <= mod_sub(d0, share_q, p_eff);
			o1_q <= mod_sub(d1, share_q, p_eff);
			os_q <= share_q;
			od_q <= dim_q;
			ol_q <= last_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, od_q, os_q, o1_q, o0_q};
	assign m_tlast  = ol_q;

	pps_ram #(.WIDTH(32), .DEPTH(DB_DEPTH)) u_db (
		.clk   (clk),
		.we    (db_we),
		.waddr (db_waddr),
		.wdata (in_db),
		.re    (rd_issue),
		.raddr ({entry_q, idx_q[DW-1:0]}),
		.rdata (db_rd)
	);

	pps_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_acc0 (
		.clk   (clk),
		.we    (acc_we0),
		.waddr (acc_waddr),
		.wdata (acc_wd0),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (a0_rd)
	);

	pps_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_acc1 (
		.clk   (clk),
		.we    (acc_we1),
		.waddr (acc_waddr),
		.wdata (acc_wd1),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (a1_rd)
	);

	pps_divmod u_divmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.plain   (p_eff),
		.stat    (div_stat),
		.rem     (div_rem),
		.quo_mod (div_qm)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy)
		else $error("item accepted while remainder unit busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy && !div_stat.done)
		else $error("remainder unit restarted while running");

	a_acc_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_we0 || acc_we1) |-> (32'(acc_waddr) < MAX_DIM))
		else $error("accumulator write beyond MAX_DIM");

	a_read_write_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && (acc_we0 || acc_we1)) |-> (acc_waddr != idx_q[DW-1:0]))
		else $error("accumulator read and write of the same word");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for pir_partition_sum_and_share: loads, row selects and finishes
// are predicted in the bench and each output word is compared field by field.
// Depends on pps_pkg and the RTL under rtl/core only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pps_pkg::*;

	localparam int MAX_WORDS = 128;
	localparam int ROWS_PER_PART = 32;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic [31:0] share_zero;
		logic [31:0] share_one;
		logic [31:0] srv_share;
		logic [6:0]  out_dim;
		logic        tail;
	} share_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [191:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	// bench copy of registers and state
	logic [31:0] plain_p = 32'd65537;
	logic [61:0] cipher_q = 62'h1000_0000_0000_0000;
	logic [7:0] emb_words = 8'd128;
	logic [31:0] db_words[int];
	logic [31:0] acc_zero[MAX_WORDS];
	logic [31:0] acc_one[MAX_WORDS];
	int ready_entries[$];

	share_word_t pending_shares[$];
	int errors = 0;
	int items_sent = 0;
	int words_checked = 0;
	bit idle_on = 1'b1;
	int stall_left = 0;

	pir_partition_sum_and_share dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 17);
		m_tready <= (stall_left == 0);
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// compare each output word with the oldest pending share set
	always @(posedge clk) begin
		share_word_t want;
		if (m_tvalid && m_tready) begin
			words_checked++;
			if (pending_shares.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", m_tdata));
			end else begin
				want = pending_shares.pop_front();
				if (m_tdata[31:0] !== want.share_zero)
					report_mismatch($sformatf("share_zero %h want %h", m_tdata[31:0],
						want.share_zero));
				if (m_tdata[63:32] !== want.share_one)
					report_mismatch($sformatf("share_one %h want %h", m_tdata[63:32],
						want.share_one));
				if (m_tdata[95:64] !== want.srv_share)
					report_mismatch($sformatf("srv_share %h want %h", m_tdata[95:64],
						want.srv_share));
				if (m_tdata[102:96] !== want.out_dim)
					report_mismatch($sformatf("out_dim %0d want %0d", m_tdata[102:96],
						want.out_dim));
				if (m_tlast !== want.tail)
					report_mismatch($sformatf("last %b want %b dim %0d", m_tlast, want.tail,
						want.out_dim));
			end
		end
	end

	function automatic logic [63:0] eff_plain();
		return (plain_p == 0) ? 64'd1 : {32'd0, plain_p};
	endfunction

	// advance the bench state for one accepted word
	function automatic void apply_item(input logic [1:0] cmd, input logic [191:0] d);
		logic [9:0] entry;
		logic [6:0] dim;
		logic [61:0] coef;
		logic [63:0] rnd, p, share, a0, a1, d0, d1;
		logic [127:0] num, q, rounded;
		int ent, words;
		share_word_t res;
		entry = d[9:0];
		dim = d[16:10];
		coef = d[122:61];
		rnd = d[186:123];
		p = eff_plain();
		case (cmd)
			CMD_LOAD: db_words[{entry, dim}] = d[48:17];
			CMD_SELECT: begin
				if (d[60]) begin
					foreach (acc_zero[i]) acc_zero[i] = '0;
					foreach (acc_one[i]) acc_one[i] = '0;
				end
				ent = d[53:49] * ROWS_PER_PART + d[58:54];
				words = (emb_words < MAX_WORDS) ? emb_words : MAX_WORDS;
				for (int i = 0; i < words; i++) begin
					if (d[59])
						acc_one[i] = 32'((64'(acc_one[i]) + db_words[ent * MAX_WORDS + i]) % p);
					else
						acc_zero[i] = 32'((64'(acc_zero[i]) + db_words[ent * MAX_WORDS + i]) % p);
				end
			end
			CMD_FINISH: begin
				q = (cipher_q == 0) ? 128'd1 : 128'(cipher_q);
				num = 128'(coef) * 128'(p) + (q >> 1);
				rounded = (num / q) % 128'(p);
				share = rnd % p;
				a0 = 64'(acc_zero[dim]) % p;
				a1 = 64'(acc_one[dim]) % p;
				d0 = (64'(rounded) + p - a0) % p;
				d1 = (64'(rounded) + p - a1) % p;
				res.share_zero = 32'((d0 + p - share) % p);
				res.share_one = 32'((d1 + p - share) % p);
				res.srv_share = 32'(share);
				res.out_dim = dim;
				res.tail = (9'(dim) + 9'd1 == 9'(emb_words));
				pending_shares.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// entered just after a rising edge; returns just after the accepting edge, or after a random pause with s_tvalid low
	task automatic send_item(input logic [1:0] cmd, input logic [191:0] d);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_item(cmd, d);
		items_sent++;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic do_load(input int entry, input int dim, input logic [31:0] val);
		send_item(CMD_LOAD, {144'd0, val, 7'(dim), 10'(entry)});
	endtask

	task automatic do_select(input int entry, input bit pick_one, input bit start);
		send_item(CMD_SELECT, {131'd0, start, pick_one, 5'(entry % ROWS_PER_PART),
			5'(entry / ROWS_PER_PART), 49'd0});
	endtask

	task automatic do_finish(input int dim, input logic [61:0] coef, input logic [63:0] rnd);
		send_item(CMD_FINISH, {5'd0, rnd, coef, 44'd0, 7'(dim), 10'd0});
	endtask

	// hold until every share set has come back and the block has drained
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_shares.size() != 0) @(posedge clk);
		repeat (6000) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] p, input logic [61:0] q, input logic [7:0] emb);
		cfg_we <= 1'b1;
		cfg_addr <= REG_PLAIN_MOD;
		cfg_data <= 62'(p);
		@(posedge clk);
		cfg_addr <= REG_CIPHER_MOD;
		cfg_data <= q;
		@(posedge clk);
		cfg_addr <= REG_EMB_DIM;
		cfg_data <= 62'(emb);
		@(posedge clk);
		cfg_we <= 1'b0;
		plain_p = p;
		cipher_q = q;
		emb_words = emb;
		// old rows may hold words above the new p; only reloaded rows get selected
		db_words.delete();
		ready_entries.delete();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rand_below_p();
		return 32'(rand64() % eff_plain());
	endfunction

	task automatic load_entry(input int entry);
		int words;
		words = (emb_words < MAX_WORDS) ? emb_words : MAX_WORDS;
		for (int i = 0; i < words; i++) do_load(entry, i, rand_below_p());
		ready_entries.push_back(entry);
	endtask

	task automatic test_defaults();
		do_finish(0, '0, '0);
		do_finish(127, {62{1'b1}}, {64{1'b1}});
		send_item(CMD_NONE, {192{1'b1}});
		do_finish(5, 62'h2000_0000_0000_0000, rand64());
		wait_idle();
	endtask

	task automatic test_modulus_edges();
		// zero p and zero q registers
		set_config('0, '0, 8'd1);
		do_finish(0, {62{1'b1}}, rand64());
		do_finish(1, 62'd12345, {64{1'b1}});
		wait_idle();
		set_config(32'd2, 62'd3, 8'd1);
		do_load(0, 0, 32'd1);
		do_select(0, 1'b0, 1'b1);
		do_select(0, 1'b1, 1'b0);
		do_select(0, 1'b1, 1'b0);
		do_finish(0, 62'd2, rand64());
		do_finish(1, {62{1'b1}}, rand64());
		wait_idle();
		// zero embedding width: select adds nothing
		set_config(32'd7, 62'd3, 8'd0);
		do_select(1000, 1'b0, 1'b0);
		do_finish(0, 62'd1, rand64());
		wait_idle();
	endtask

	task automatic test_select_corners();
		set_config(32'hFFFF_FFFF, {62{1'b1}}, 8'd2);
		do_load(1023, 0, 32'hFFFF_FFFE);
		do_load(1023, 1, 32'hFFFF_FFFE);
		do_load(0, 0, 32'h5555_5555);
		do_load(0, 1, 32'hAAAA_AAAA);
		ready_entries.push_back(1023);
		do_select(1023, 1'b0, 1'b1);
		do_select(1023, 1'b0, 1'b0);
		do_select(1023, 1'b1, 1'b0);
		do_select(0, 1'b1, 1'b0);
		do_finish(0, {62{1'b1}}, {64{1'b1}});
		do_finish(1, 62'd0, 64'hFFFF_FFFE);
		wait_idle();
	endtask

	// width register above the word count: a select sums every stored word
	task automatic test_wide_rows();
		int entry;
		set_config(32'hFFFF_FFFB, 62'h3FFF_FFFF_FFFF_FFF0 | 62'($urandom), 8'd200);
		entry = $urandom_range(0, 1023);
		load_entry(entry);
		do_select(entry, 1'b0, 1'b1);
		do_select(entry, 1'b1, 1'b0);
		do_select(entry, 1'b1, 1'b0);
		for (int i = 0; i < 4; i++) do_finish($urandom_range(0, 127), 62'(rand64()), rand64());
		do_finish(127, 62'(rand64()), rand64());
		wait_idle();
	endtask

	task automatic noise_item();
		case ($urandom_range(0, 2))
			0: send_item(CMD_NONE, {rand64(), rand64(), rand64()});
			1: do_finish($urandom_range(0, 127), 62'(rand64()), rand64());
			default: do_load($urandom_range(0, 1023), $urandom_range(0, 127), rand_below_p());
		endcase
	endtask

	task automatic test_random_queries();
		logic [31:0] p;
		logic [61:0] q;
		int words;
		while (items_sent < 450) begin
			if (items_sent > 360) idle_on = 1'b0;
			case ($urandom_range(0, 3))
				0: p = $urandom_range(2, 300);
				1: p = 32'hFFFF_FFFF;
				default: p = $urandom | 32'd2;
			endcase
			case ($urandom_range(0, 2))
				0: q = $urandom_range(3, 1000);
				default: q = 62'(rand64()) | 62'd3;
			endcase
			set_config(p, q, 8'($urandom_range(0, 6)));
			words = emb_words;
			// accumulators still hold sums under the old p
			do_finish($urandom_range(0, 7), 62'(rand64()), rand64());
			for (int e = 0; e < 3; e++) load_entry($urandom_range(0, 1023));
			if (words == 0) ready_entries.push_back($urandom_range(0, 1023));
			repeat ($urandom_range(2, 4)) begin
				do_select(ready_entries[$urandom_range(0, ready_entries.size() - 1)],
					$urandom_range(0, 1), 1'b1);
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 9) == 0) noise_item();
					do_select(ready_entries[$urandom_range(0, ready_entries.size() - 1)],
						$urandom_range(0, 1), $urandom_range(0, 5) == 0);
				end
				for (int i = 0; i < (words == 0 ? 1 : words); i++) begin
					if ($urandom_range(0, 9) == 0) noise_item();
					do_finish(i, 62'(rand64()), rand64());
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		#(40_000_000);
		$display("timeout: %0d words pending", pending_shares.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		foreach (acc_zero[i]) acc_zero[i] = '0;
		foreach (acc_one[i]) acc_one[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_modulus_edges();
		test_select_corners();
		test_wide_rows();
		test_random_queries();
		repeat (300) @(posedge clk);
		$display("covered %0d input words and %0d share words", items_sent, words_checked);
		$display("modulus edges, wide rows, stale sums and random partition queries run");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
